/* design/websocket_header_parser_core_assert.svh */
// assertion macros for the websocket header parser core
// expects clk and rst_n in the scope of each use; no other dependencies
`ifndef WEBSOCKET_HEADER_PARSER_CORE_ASSERT_SVH
`define WEBSOCKET_HEADER_PARSER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define WSHP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wshp assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define WSHP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wshp assertion failed: next-cycle implication");

`else

`define WSHP_ASSERT_IMP(lbl, ante, cons)
`define WSHP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* design/wshp_pkg.sv */
// shared types, codes and helpers for the websocket header parser
// no dependencies; used by wshp_step and websocket_header_parser_core
`timescale 1ns / 1ps
`default_nettype none

package wshp_pkg;

  localparam int LenW = 63;
  localparam int KeyW = 32;
  localparam int OutTdataW = 112;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] EXT_NONE = 4'd0;
  localparam logic [3:0] EXT_16 = 4'd2;
  localparam logic [3:0] EXT_64 = 4'd8;
  localparam logic [3:0] PHASE_FIRST = 4'd0;
  localparam logic [3:0] PHASE_SECOND = 4'd1;
  localparam logic [3:0] PHASE_EXT = 4'd2;
  localparam logic [3:0] PHASE_LAST = 4'd13;
  localparam logic [3:0] HDR_BASE = 4'd2;
  localparam logic [3:0] HDR_KEYED = 4'd6;
  localparam logic [3:0] KEY_LAST_IDX = 4'd3;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_RSV     = 3'd1,
    STAT_OPCODE  = 3'd2,
    STAT_LEN16   = 3'd3,
    STAT_LEN_MSB = 3'd4,
    STAT_LEN64   = 3'd5
  } status_t;

  typedef struct packed {
    logic [3:0]      phase;
    logic            fin;
    logic [3:0]      opcode;
    logic            mask;
    logic [6:0]      length_code;
    logic [LenW-1:0] length_accum;
    logic [KeyW-1:0] key_accum;
  } parser_state_t;

  typedef struct packed {
    status_t         status;
    logic            fin_flag;
    logic [3:0]      opcode_out;
    logic            is_control_frame;
    logic            masked;
    logic [LenW-1:0] body_length;
    logic [KeyW-1:0] key_word;
    logic [3:0]      header_length;
  } result_t;

  // opcodes 0..2 (data) and 8..10 (control)
  function automatic logic opcode_known(logic [3:0] op);
    return (op <= 4'd2) || ((op >= 4'd8) && (op <= 4'd10));
  endfunction

  // good result from the gathered header fields
  function automatic result_t ok_result(parser_state_t s, logic [3:0] hdr_len);
    result_t r;
    r.status           = STAT_OK;
    r.fin_flag         = s.fin;
    r.opcode_out       = s.opcode;
    r.is_control_frame = s.opcode[3];
    r.masked           = s.mask;
    r.body_length      = s.length_accum;
    r.key_word         = s.mask ? s.key_accum : '0;
    r.header_length    = hdr_len;
    return r;
  endfunction

  function automatic result_t err_result(status_t code);
    result_t r;
    r = '0;
    r.status = code;
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/wshp_step.sv */
// per-byte header parse step: next parser state and optional result
// depends on wshp_pkg
`timescale 1ns / 1ps
`default_nettype none

module wshp_step (
  input  wire logic                  sof,
  input  wire logic [7:0]            data_byte,
  input  wire wshp_pkg::parser_state_t cur,
  output wshp_pkg::parser_state_t    nxt,
  output logic                       emit,
  output wshp_pkg::result_t          res
);

  logic [3:0]                 ext;
  logic [3:0]                 idx;
  logic [3:0]                 key_idx;
  logic [wshp_pkg::LenW-1:0]  acc_shift;
  logic                       short_len;

  assign short_len = (data_byte[6:0] < wshp_pkg::LEN_CODE_16);
  assign ext = (cur.length_code == wshp_pkg::LEN_CODE_16) ? wshp_pkg::EXT_16 :
               (cur.length_code == wshp_pkg::LEN_CODE_64) ? wshp_pkg::EXT_64 :
               wshp_pkg::EXT_NONE;
  assign idx       = cur.phase - wshp_pkg::PHASE_EXT;
  assign key_idx   = idx - ext;
  assign acc_shift = {cur.length_accum[wshp_pkg::LenW-9:0], data_byte};

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    res  = '0;
    if (sof || (cur.phase == wshp_pkg::PHASE_FIRST)) begin
      nxt = '0;
      if (data_byte[6:4] != 3'd0) begin
        emit = 1'b1;
        res  = wshp_pkg::err_result(wshp_pkg::STAT_RSV);
      end else if (!wshp_pkg::opcode_known(data_byte[3:0])) begin
        emit = 1'b1;
        res  = wshp_pkg::err_result(wshp_pkg::STAT_OPCODE);
      end else begin
        nxt.fin    = data_byte[7];
        nxt.opcode = data_byte[3:0];
        nxt.phase  = wshp_pkg::PHASE_SECOND;
      end
    end else if (cur.phase == wshp_pkg::PHASE_SECOND) begin
      nxt.mask         = data_byte[7];
      nxt.length_code  = data_byte[6:0];
      nxt.length_accum = short_len ? {56'd0, data_byte[6:0]} : '0;
      nxt.phase        = wshp_pkg::PHASE_EXT;
      if (short_len && !data_byte[7]) begin
        emit = 1'b1;
        res  = wshp_pkg::ok_result(nxt, wshp_pkg::HDR_BASE);
        nxt  = '0;
      end
    end else if (cur.phase > wshp_pkg::PHASE_LAST) begin
      nxt = '0;
    end else if (idx < ext) begin
      // extended length bytes, most significant first
      if ((ext == wshp_pkg::EXT_64) && (idx == 4'd0) && data_byte[7]) begin
        emit = 1'b1;
        res  = wshp_pkg::err_result(wshp_pkg::STAT_LEN_MSB);
        nxt  = '0;
      end else begin
        nxt.length_accum = acc_shift;
        nxt.phase        = cur.phase + 4'd1;
        if (idx == (ext - 4'd1)) begin
          if ((ext == wshp_pkg::EXT_16) &&
              (acc_shift < {56'd0, wshp_pkg::LEN_CODE_16})) begin
            emit = 1'b1;
            res  = wshp_pkg::err_result(wshp_pkg::STAT_LEN16);
            nxt  = '0;
          end else if ((ext == wshp_pkg::EXT_64) &&
                       (acc_shift[wshp_pkg::LenW-1:16] == '0)) begin
            emit = 1'b1;
            res  = wshp_pkg::err_result(wshp_pkg::STAT_LEN64);
            nxt  = '0;
          end else if (!cur.mask) begin
            emit = 1'b1;
            res  = wshp_pkg::ok_result(nxt, wshp_pkg::HDR_BASE + ext);
            nxt  = '0;
          end
        end
      end
    end else begin
      // masking key bytes, first byte ends up most significant
      nxt.key_accum = {cur.key_accum[wshp_pkg::KeyW-9:0], data_byte};
      nxt.phase     = cur.phase + 4'd1;
      if (key_idx >= wshp_pkg::KEY_LAST_IDX) begin
        emit = 1'b1;
        res  = wshp_pkg::ok_result(nxt, wshp_pkg::HDR_KEYED + ext);
        nxt  = '0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/websocket_header_parser_core.sv */
// websocket frame header parser, top level with stream ports
// depends on wshp_pkg, wshp_step and websocket_header_parser_core_assert.svh
//
//  channel | dir | tdata / tuser                              | meaning
//  in_     | in  | tdata[7:0] data_byte, tuser[0] sof flag    | one header byte per beat
//  out_    | out | tdata[108:0] result fields (see port list) | one beat per finished
//          |     |                                            | header or per fault
//
// one byte is taken per cycle while in_tready is high; the parse state updates at the accepting edge
// a result beat shows on out_ in the cycle after the byte that completes or faults
// the header, held in the output register until taken
// in_tready drops only while that register is full and out_tready is low
// rst_n (synchronous) clears the parse state and the output valid
`timescale 1ns / 1ps
`default_nettype none

module websocket_header_parser_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,  // [7:0] data_byte
  input  wire logic [0:0]                     in_tuser,  // [0] start_of_header
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [2:0] status, [3] fin_flag, [7:4] opcode_out, [8] is_control_frame,
  // [9] masked, [72:10] body_length, [104:73] key_word,
  // [108:105] header_length, [111:109] zero
  output logic [wshp_pkg::OutTdataW-1:0]      out_tdata
);

  `include "websocket_header_parser_core_assert.svh"

  wshp_pkg::parser_state_t state_r;
  wshp_pkg::parser_state_t state_nxt;
  wshp_pkg::result_t       res_r;
  wshp_pkg::result_t       step_res;
  logic                    step_emit;
  logic                    out_valid_r;
  logic                    in_acc;

  // the output register frees itself in the same cycle it is taken
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  wshp_step u_step (
    .sof       (in_tuser[0]),
    .data_byte (in_tdata),
    .cur       (state_r),
    .nxt       (state_nxt),
    .emit      (step_emit),
    .res       (step_res)
  );

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && step_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc && step_emit) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, res_r.header_length, res_r.key_word, res_r.body_length,
                       res_r.masked, res_r.is_control_frame, res_r.opcode_out,
                       res_r.fin_flag, res_r.status};

  // a fault beat carries only its code
  `WSHP_ASSERT_IMP(a_err_no_len, out_valid_r && (res_r.status != wshp_pkg::STAT_OK), res_r.header_length == 4'd0)
  // a good beat spans 2 to 14 header bytes
  `WSHP_ASSERT_IMP(a_ok_len, out_valid_r && (res_r.status == wshp_pkg::STAT_OK), (res_r.header_length >= 4'd2) && (res_r.header_length <= 4'd14))
  // an unmasked frame reports a zero key
  `WSHP_ASSERT_IMP(a_key_zero, out_valid_r && (res_r.status == wshp_pkg::STAT_OK) && !res_r.masked, res_r.key_word == '0)
  // every emitted beat leaves the parser expecting a first byte
  `WSHP_ASSERT_NXT(a_idle_after, in_acc && step_emit, (state_r.phase == wshp_pkg::PHASE_FIRST) && out_valid_r)
  // phase never runs past the last key byte
  `WSHP_ASSERT_IMP(a_phase_range, 1'b1, state_r.phase <= wshp_pkg::PHASE_LAST)

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// self-checking testbench for websocket_header_parser_core: directed and random header bytes
// drives the in_ stream, predicts each result beat and checks the out_ stream field by field
// depends on wshp_pkg and the websocket_header_parser_core rtl
`timescale 1ns / 1ps

module tb_top;

  // frame opcodes
  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  // one decoded header as it should leave the block
  typedef struct packed {
    wshp_pkg::status_t status;
    logic        fin;
    logic [3:0]  opcode;
    logic        control;
    logic        masked;
    logic [62:0] body_len;
    logic [31:0] key;
    logic [3:0]  hdr_len;
  } header_fields_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'h00;  // [7:0] data_byte
  logic [0:0]           in_tuser = 1'b0;   // [0] start_of_header
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [2:0] status, [3] fin_flag, [7:4] opcode_out, [8] is_control_frame, [9] masked,
  // [72:10] body_length, [104:73] key_word, [108:105] header_length, [111:109] zero
  logic [wshp_pkg::OutTdataW-1:0] out_tdata;

  websocket_header_parser_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // predictor copy of the parse state
  int          hdr_phase;
  logic        hdr_fin;
  logic [3:0]  hdr_opcode;
  logic        hdr_mask;
  logic [6:0]  hdr_len_code;
  logic [62:0] hdr_body_len;
  logic [31:0] hdr_key;

  header_fields_t expected_headers[$];
  int             mismatch_count = 0;
  int             bytes_sent = 0;
  bit             in_idle_on = 1'b1;
  logic           out_stall_on = 1'b1;
  int             stall_left = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    // keep the log bounded if the block is badly broken
    if (mismatch_count < 100)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic clear_header();
    hdr_phase    = 0;
    hdr_fin      = 1'b0;
    hdr_opcode   = 4'd0;
    hdr_mask     = 1'b0;
    hdr_len_code = 7'd0;
    hdr_body_len = '0;
    hdr_key      = '0;
  endtask

  task automatic push_fault(input wshp_pkg::status_t code);
    header_fields_t r;
    r = '0;
    r.status = code;
    expected_headers.push_back(r);
    clear_header();
  endtask

  task automatic push_header(input int hdr_len);
    header_fields_t r;
    r.status   = wshp_pkg::STAT_OK;
    r.fin      = hdr_fin;
    r.opcode   = hdr_opcode;
    r.control  = (hdr_opcode >= OP_CLOSE);
    r.masked   = hdr_mask;
    r.body_len = hdr_body_len;
    r.key      = hdr_mask ? hdr_key : 32'd0;
    r.hdr_len  = hdr_len[3:0];
    expected_headers.push_back(r);
    clear_header();
  endtask

  // advance the predicted parse by one accepted byte
  task automatic decode_header_byte(input logic [7:0] b, input logic sof);
    int ext_len;
    int idx;
    if (sof || hdr_phase == 0) begin
      // first byte: reserved bits and opcode are judged right here
      clear_header();
      if (b[6:4] != 3'b000) begin
        push_fault(wshp_pkg::STAT_RSV);
      end else if (!(b[3:0] <= OP_BINARY || (b[3:0] >= OP_CLOSE && b[3:0] <= OP_PONG))) begin
        push_fault(wshp_pkg::STAT_OPCODE);
      end else begin
        hdr_fin    = b[7];
        hdr_opcode = b[3:0];
        hdr_phase  = 1;
      end
    end else if (hdr_phase == 1) begin
      hdr_mask     = b[7];
      hdr_len_code = b[6:0];
      hdr_body_len = (b[6:0] < wshp_pkg::LEN_CODE_16) ? 63'(b[6:0]) : '0;
      hdr_phase    = 2;
      if (b[6:0] < wshp_pkg::LEN_CODE_16 && !b[7])
        push_header(2);
    end else if (hdr_phase < 2 || hdr_phase > 13) begin
      clear_header();
    end else begin
      ext_len = (hdr_len_code == wshp_pkg::LEN_CODE_16) ? 2 :
                (hdr_len_code == wshp_pkg::LEN_CODE_64) ? 8 : 0;
      idx = hdr_phase - 2;
      if (idx < ext_len) begin
        if (ext_len == 8 && idx == 0 && b[7]) begin
          push_fault(wshp_pkg::STAT_LEN_MSB);
        end else begin
          hdr_body_len = {hdr_body_len[54:0], b};
          hdr_phase++;
          if (idx == ext_len - 1) begin
            // minimal-encoding checks once the whole extended length is in
            if (ext_len == 2 && hdr_body_len < 63'd126)
              push_fault(wshp_pkg::STAT_LEN16);
            else if (ext_len == 8 && hdr_body_len <= 63'hFFFF)
              push_fault(wshp_pkg::STAT_LEN64);
            else if (!hdr_mask)
              push_header(2 + ext_len);
          end
        end
      end else begin
        hdr_key = {hdr_key[23:0], b};
        hdr_phase++;
        if (idx - ext_len >= 3)
          push_header(6 + ext_len);
      end
    end
  endtask

  // one beat on the in_ channel, with an optional idle burst in front
  task automatic send_byte(input logic [7:0] b, input logic sof);
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tuser[0] <= sof;
    do @(posedge clk); while (!in_tready);
    decode_header_byte(b, sof);
    bytes_sent++;
  endtask

  task automatic wait_results_drained(input int max_cycles);
    int waited;
    waited = 0;
    while (expected_headers.size() != 0 && waited < max_cycles) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // out_ back-pressure: random stall bursts while enabled
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_stall_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker: every accepted beat against the oldest expectation
  always @(posedge clk) begin
    header_fields_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_headers.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_tdata[63:0], 64'd0);
      end else begin
        want = expected_headers.pop_front();
        if (out_tdata[2:0] != want.status)
          report_mismatch("status", out_tdata[2:0], want.status);
        if (out_tdata[3] != want.fin)
          report_mismatch("fin_flag", out_tdata[3], want.fin);
        if (out_tdata[7:4] != want.opcode)
          report_mismatch("opcode_out", out_tdata[7:4], want.opcode);
        if (out_tdata[8] != want.control)
          report_mismatch("is_control_frame", out_tdata[8], want.control);
        if (out_tdata[9] != want.masked)
          report_mismatch("masked", out_tdata[9], want.masked);
        if (out_tdata[72:10] != want.body_len)
          report_mismatch("body_length", out_tdata[72:10], want.body_len);
        if (out_tdata[104:73] != want.key)
          report_mismatch("key_word", out_tdata[104:73], want.key);
        if (out_tdata[108:105] != want.hdr_len)
          report_mismatch("header_length", out_tdata[108:105], want.hdr_len);
        if (out_tdata[111:109] != 3'd0)
          report_mismatch("tdata padding", out_tdata[111:109], 64'd0);
      end
    end
  end

  // one random header: mostly well formed, some broken, some noise
  task automatic send_random_header();
    logic [7:0]  hb [0:13];
    logic [63:0] len64;
    logic [15:0] len16;
    logic [3:0]  op;
    logic        mask;
    int          n;
    int          kind;
    int          sel;
    int          nbits;
    logic        first_sof;
    kind = $urandom_range(0, 99);
    first_sof = ($urandom_range(0, 9) != 0);
    if (kind < 75) begin
      case ($urandom_range(0, 5))
        0: op = OP_CONT;
        1: op = OP_TEXT;
        2: op = OP_BINARY;
        3: op = OP_CLOSE;
        4: op = OP_PING;
        default: op = OP_PONG;
      endcase
      mask  = 1'($urandom_range(0, 1));
      hb[0] = {1'($urandom_range(0, 1)), 3'b000, op};
      case ($urandom_range(0, 2))
        0: begin
          // short length in the second byte
          sel = $urandom_range(0, 9);
          hb[1] = {mask, (sel == 0) ? 7'd0 : (sel == 1) ? 7'd125 : 7'($urandom_range(0, 125))};
          n = 2;
        end
        1: begin
          sel = $urandom_range(0, 9);
          if (sel == 0)      len16 = 16'($urandom_range(0, 125));
          else if (sel == 1) len16 = 16'hFFFF;
          else if (sel == 2) len16 = 16'd126;
          else               len16 = 16'($urandom_range(126, 65535));
          hb[1] = {mask, wshp_pkg::LEN_CODE_16};
          hb[2] = len16[15:8];
          hb[3] = len16[7:0];
          n = 4;
        end
        default: begin
          sel = $urandom_range(0, 9);
          len64 = {$urandom, $urandom};
          if (sel == 0) begin
            len64[63] = 1'b1;
          end else if (sel == 1) begin
            len64 = 64'($urandom_range(0, 65535));
          end else if (sel == 2) begin
            len64 = 64'h7FFF_FFFF_FFFF_FFFF;
          end else if (sel == 3) begin
            len64 = 64'h1_0000;
          end else begin
            nbits = $urandom_range(17, 63);
            len64 = len64 & ((64'd1 << nbits) - 64'd1);
            len64[nbits-1] = 1'b1;
          end
          hb[1] = {mask, wshp_pkg::LEN_CODE_64};
          for (int i = 0; i < 8; i++)
            hb[2+i] = len64[63-8*i -: 8];
          n = 10;
        end
      endcase
      if (mask) begin
        for (int i = 0; i < 4; i++)
          hb[n+i] = 8'($urandom_range(0, 255));
        n += 4;
      end
      // now and then cut the header short so the next one restarts mid-header
      if ($urandom_range(0, 9) == 0)
        n = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++)
        send_byte(hb[i], (i == 0) ? first_sof : 1'b0);
    end else if (kind < 90) begin
      // broken header: any first byte, then up to five random bytes
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)), (i == 0) ? first_sof : 1'b0);
    end else begin
      // noise with a random start flag on every byte
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic apply_reset();
    clear_header();
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_directed_headers();
    // final text frame, empty payload, unmasked
    send_byte({1'b1, 3'b000, OP_TEXT}, 1'b1);
    send_byte(8'h00, 1'b0);
    // reserved bits set, all ones
    send_byte(8'hFF, 1'b1);
    // idle without a start flag, unknown opcode
    send_byte({1'b0, 3'b000, 4'hB}, 1'b0);
    // 16-bit length that fits in seven bits
    send_byte({1'b1, 3'b000, OP_CLOSE}, 1'b1);
    send_byte({1'b1, wshp_pkg::LEN_CODE_16}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7D, 1'b0);
    // 64-bit length with its top bit set
    send_byte({1'b0, 3'b000, OP_PING}, 1'b1);
    send_byte({1'b0, wshp_pkg::LEN_CODE_64}, 1'b0);
    send_byte(8'h80, 1'b0);
    // start flag in the middle of a header drops the partial one
    send_byte({1'b1, 3'b000, OP_BINARY}, 1'b1);
    send_byte({1'b1, 3'b000, OP_PONG}, 1'b1);
    send_byte({1'b1, 7'd125}, 1'b0);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hEF, 1'b0);
    // 64-bit length that fits in sixteen bits
    send_byte({1'b0, 3'b000, OP_BINARY}, 1'b1);
    send_byte({1'b0, wshp_pkg::LEN_CODE_64}, 1'b0);
    for (int i = 0; i < 6; i++)
      send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_random_headers(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      // change the idle pattern now and then so quiet stretches occur too
      if ($urandom_range(0, 7) == 0) begin
        in_idle_on = ($urandom_range(0, 2) != 0);
        out_stall_on <= ($urandom_range(0, 2) != 0);
      end
      send_random_header();
    end
  endtask

  // sender holds off until every pending result has been taken or the wait gives up
  task automatic test_drain_pause();
    in_tvalid <= 1'b0;
    wait_results_drained(20000);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_no_idle_tail(input int n_bytes);
    int target;
    in_idle_on = 1'b0;
    out_stall_on <= 1'b0;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target)
      send_random_header();
    in_tvalid <= 1'b0;
  endtask

  initial begin
    apply_reset();
    test_directed_headers();
    test_random_headers(450);
    test_drain_pause();
    test_random_headers(400);
    test_no_idle_tail(150);
    wait_results_drained(20000);
    if (expected_headers.size() != 0)
      report_mismatch("expected results never arrived", expected_headers.size(), 64'd0);
    // a result beat shows in the cycle after its byte; leave room for a stray one
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/wshp_pkg.sv
design/wshp_step.sv
design/websocket_header_parser_core.sv
tb/sv/tb_top.sv
